// ===== hw/rtl/lcdn_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD nibble interface package
// Shared widths, operation codes, LCD command bytes and the job record that
// travels from the front end to the port sequencer.
// ----------------------------------------------------------------------------
package lcdn_pkg;

  localparam int WAIT_BITS    = 18;
  localparam int PHASE_BITS   = 4;
  localparam int INIT_REPEATS = 3;
  localparam int ADDR_BITS    = 4;
  localparam int DATA_BITS    = 32;
  localparam int QUEUE_DEPTH  = 2;

  // Init phases after the repeated 8-bit function sets.
  localparam logic [PHASE_BITS-1:0] PH_SWITCH = PHASE_BITS'(INIT_REPEATS + 1);
  localparam logic [PHASE_BITS-1:0] PH_FUNC   = PHASE_BITS'(INIT_REPEATS + 2);
  localparam logic [PHASE_BITS-1:0] PH_DISP   = PHASE_BITS'(INIT_REPEATS + 3);
  localparam logic [PHASE_BITS-1:0] PH_CLEAR  = PHASE_BITS'(INIT_REPEATS + 4);
  localparam logic [PHASE_BITS-1:0] PH_FIRST  = PHASE_BITS'(1);
  localparam logic [PHASE_BITS-1:0] PH_NONE   = '0;

  localparam logic [WAIT_BITS-1:0] POWERUP_RESET = WAIT_BITS'(200000);
  localparam logic [WAIT_BITS-1:0] SHORT_RESET   = WAIT_BITS'(250);
  localparam logic [WAIT_BITS-1:0] CLEAR_RESET   = WAIT_BITS'(5000);

  localparam logic [7:0] CMD_FUNC_8BIT  = 8'h30;
  localparam logic [7:0] CMD_FUNC_4BIT  = 8'h20;
  localparam logic [7:0] CMD_FUNC_2LINE = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0c;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_DATA  = 3'd1,
    OP_CMD   = 3'd2,
    OP_CLEAR = 3'd3,
    OP_INIT  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    REG_POWERUP = 2'd0,
    REG_SHORT   = 2'd1,
    REG_CLEAR   = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    JOB_REJECT = 2'd0,
    JOB_HALF   = 2'd1,
    JOB_FULL   = 2'd2
  } job_kind_e;

  typedef struct packed {
    logic [WAIT_BITS-1:0] powerup_wait;
    logic [WAIT_BITS-1:0] short_wait;
    logic [WAIT_BITS-1:0] clear_wait;
  } cfg_t;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] byte_value;
    logic       sel;
  } job_t;

endpackage

// ===== hw/rtl/char_lcd_nibble_interface.sv =====
// ----------------------------------------------------------------------------
// Character LCD nibble interface
// Drives a character LCD over a 4-bit bus through an 8-bit port.
// ----------------------------------------------------------------------------
// Each accepted transaction is decoded at once by the front end, which keeps
// the wait counter and init phase, and queued as a job in a two-entry queue.
// An init start or ignored code queues nothing, nor does a tick unless it ends
// an init phase's wait. A rejected write produces one port transaction; a data,
// command or clear item (and the last three init phases) produces four, an early
// init phase two. The port sequencer issues one port transaction per cycle
// unless the output stalls, so the output port sets the pace of byte writes.
// Input transactions keep being accepted while the queue has room, even when
// the output is stalled. Wait registers sit at byte addresses 0, 4 and 8.
module char_lcd_nibble_interface (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [2:0] operation, [10:3] byte_value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] port_value
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o,  // [0] rejected
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lcdn_pkg::cfg_t cfg;
  lcdn_pkg::job_t push_job, head_job;
  logic           push, pop, q_full, q_valid;

  lcdn_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lcdn_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .operation_i  (s_axis_tdata_i[2:0]),
    .byte_value_i (s_axis_tdata_i[10:3]),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  lcdn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  lcdn_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_valid),
    .job_i        (head_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .port_value_o (m_axis_tdata_o),
    .last_o       (m_axis_tlast_o),
    .rejected_o   (m_axis_tuser_o)
  );

endmodule

// ===== hw/rtl/lcdn_cfg.sv =====
// ----------------------------------------------------------------------------
// LCD nibble interface register file
// APB-style access to the three wait registers.
// ----------------------------------------------------------------------------
module lcdn_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcdn_pkg::ADDR_BITS-1:0] paddr,
  input  logic [lcdn_pkg::DATA_BITS-1:0] pwdata,
  output logic [lcdn_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready,
  output lcdn_pkg::cfg_t                cfg_o
);

  lcdn_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  lcdn_pkg::reg_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = lcdn_pkg::reg_e'(paddr[lcdn_pkg::ADDR_BITS-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        lcdn_pkg::REG_POWERUP: cfg_d.powerup_wait = pwdata[lcdn_pkg::WAIT_BITS-1:0];
        lcdn_pkg::REG_SHORT:   cfg_d.short_wait   = pwdata[lcdn_pkg::WAIT_BITS-1:0];
        lcdn_pkg::REG_CLEAR:   cfg_d.clear_wait   = pwdata[lcdn_pkg::WAIT_BITS-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lcdn_pkg::REG_POWERUP: prdata = lcdn_pkg::DATA_BITS'(cfg_q.powerup_wait);
      lcdn_pkg::REG_SHORT:   prdata = lcdn_pkg::DATA_BITS'(cfg_q.short_wait);
      lcdn_pkg::REG_CLEAR:   prdata = lcdn_pkg::DATA_BITS'(cfg_q.clear_wait);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.powerup_wait <= lcdn_pkg::POWERUP_RESET;
      cfg_q.short_wait   <= lcdn_pkg::SHORT_RESET;
      cfg_q.clear_wait   <= lcdn_pkg::CLEAR_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/lcdn_front.sv =====
// ----------------------------------------------------------------------------
// LCD nibble interface front end
// Accepts items, keeps the wait counter and init phase, and turns each item
// into at most one job for the port sequencer.
// ----------------------------------------------------------------------------
module lcdn_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcdn_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          operation_i,
  input  logic [7:0]          byte_value_i,
  input  logic                q_full_i,
  output logic                push_o,
  output lcdn_pkg::job_t      job_o
);

  logic [lcdn_pkg::WAIT_BITS-1:0]  wait_q, wait_d, wait_dec, wait_sum;
  logic [lcdn_pkg::WAIT_BITS:0]    sum_wide;
  logic [lcdn_pkg::PHASE_BITS-1:0] phase_q, phase_d;
  logic                            accept, busy, has_job;
  lcdn_pkg::op_e                   op;

  assign op         = lcdn_pkg::op_e'(operation_i);
  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign busy       = (wait_q != '0) || (phase_q != lcdn_pkg::PH_NONE);
  assign wait_dec   = (wait_q != '0) ? wait_q - 1'b1 : wait_q;

  // Clear wait saturates at the counter's full scale.
  assign sum_wide = {1'b0, cfg_i.short_wait} + {1'b0, cfg_i.clear_wait};
  assign wait_sum = sum_wide[lcdn_pkg::WAIT_BITS] ? '1 : sum_wide[lcdn_pkg::WAIT_BITS-1:0];

  always_comb begin
    wait_d  = wait_q;
    phase_d = phase_q;
    has_job = 1'b0;
    job_o   = '{kind: lcdn_pkg::JOB_REJECT, byte_value: 8'h00, sel: 1'b0};
    case (op)
      lcdn_pkg::OP_TICK: begin
        wait_d = wait_dec;
        if (wait_dec == '0 && phase_q != lcdn_pkg::PH_NONE) begin
          has_job = 1'b1;
          wait_d  = cfg_i.short_wait;
          phase_d = phase_q + 1'b1;
          if (phase_q < lcdn_pkg::PH_SWITCH) begin
            job_o.kind       = lcdn_pkg::JOB_HALF;
            job_o.byte_value = lcdn_pkg::CMD_FUNC_8BIT;
          end else if (phase_q == lcdn_pkg::PH_SWITCH) begin
            job_o.kind       = lcdn_pkg::JOB_HALF;
            job_o.byte_value = lcdn_pkg::CMD_FUNC_4BIT;
          end else if (phase_q == lcdn_pkg::PH_FUNC) begin
            job_o.kind       = lcdn_pkg::JOB_FULL;
            job_o.byte_value = lcdn_pkg::CMD_FUNC_2LINE;
          end else if (phase_q == lcdn_pkg::PH_DISP) begin
            job_o.kind       = lcdn_pkg::JOB_FULL;
            job_o.byte_value = lcdn_pkg::CMD_DISPLAY_ON;
          end else begin
            job_o.kind       = lcdn_pkg::JOB_FULL;
            job_o.byte_value = lcdn_pkg::CMD_CLEAR;
            wait_d           = wait_sum;
            phase_d          = lcdn_pkg::PH_NONE;
          end
        end
      end
      lcdn_pkg::OP_DATA, lcdn_pkg::OP_CMD, lcdn_pkg::OP_CLEAR: begin
        has_job = 1'b1;
        if (!busy) begin
          job_o.kind = lcdn_pkg::JOB_FULL;
          job_o.sel  = (op == lcdn_pkg::OP_DATA);
          if (op == lcdn_pkg::OP_CLEAR) begin
            job_o.byte_value = lcdn_pkg::CMD_CLEAR;
            wait_d           = wait_sum;
          end else begin
            job_o.byte_value = byte_value_i;
            wait_d           = cfg_i.short_wait;
          end
        end
      end
      lcdn_pkg::OP_INIT: begin
        wait_d  = cfg_i.powerup_wait;
        phase_d = lcdn_pkg::PH_FIRST;
      end
      default: begin
        wait_d  = wait_q;
        phase_d = phase_q;
      end
    endcase
  end

  assign push_o = accept & has_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q  <= '0;
      phase_q <= lcdn_pkg::PH_NONE;
    end else if (accept) begin
      wait_q  <= wait_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ===== hw/rtl/lcdn_queue.sv =====
// ----------------------------------------------------------------------------
// LCD nibble interface job queue
// Two-entry FIFO between the front end and the port sequencer.
// ----------------------------------------------------------------------------
module lcdn_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lcdn_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output lcdn_pkg::job_t job_o
);

  localparam int PTR_BITS = $clog2(lcdn_pkg::QUEUE_DEPTH);

  lcdn_pkg::job_t            mem_q [lcdn_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0]       wr_ptr_q, rd_ptr_q;
  logic [PTR_BITS:0]         count_q;

  assign full_o  = (count_q == (PTR_BITS+1)'(lcdn_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/lcdn_back.sv =====
// ----------------------------------------------------------------------------
// LCD nibble interface port sequencer
// Expands each job into its port writes, one per cycle while the output is
// not stalled, into an output register.
// ----------------------------------------------------------------------------
module lcdn_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  lcdn_pkg::job_t job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     port_value_o,
  output logic           last_o,
  output logic           rejected_o
);

  logic [1:0] beat_q;
  logic       load, beat_last;
  logic [3:0] nibble;
  logic [7:0] port_d;
  logic       out_valid_q, last_q, rejected_q;
  logic [7:0] port_q;

  assign load = job_valid_i & (~out_valid_q | out_ready_i);

  // Even beats raise the enable strobe; beats two and three carry the low nibble.
  assign nibble = beat_q[1] ? job_i.byte_value[3:0] : job_i.byte_value[7:4];

  always_comb begin
    case (job_i.kind)
      lcdn_pkg::JOB_REJECT: begin
        beat_last = 1'b1;
        port_d    = 8'h00;
      end
      lcdn_pkg::JOB_HALF: begin
        beat_last = beat_q[0];
        port_d    = {nibble, ~beat_q[0], job_i.sel, 2'b00};
      end
      default: begin
        beat_last = beat_q[1] & beat_q[0];
        port_d    = {nibble, ~beat_q[0], job_i.sel, 2'b00};
      end
    endcase
  end

  assign pop_o = load & beat_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      port_q     <= port_d;
      last_q     <= beat_last;
      rejected_q <= (job_i.kind == lcdn_pkg::JOB_REJECT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        beat_q <= beat_last ? 2'd0 : beat_q + 2'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign port_value_o = port_q;
  assign last_o       = last_q;
  assign rejected_o   = rejected_q;

endmodule

// ===== hw/rtl/lcdn_checker.sv =====
// ----------------------------------------------------------------------------
// LCD nibble interface checker
// Port-level properties of the output stream, bound to the top level.
// ----------------------------------------------------------------------------
module lcdn_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic       m_axis_tuser_o
);

  // A rejected write is a single transaction with an all-zero port value.
  a_reject_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && m_axis_tdata_o == 8'h00)
    else $error("rejected transaction with nonzero port or without last");

  // A strobe-high write is always followed by its strobe-low partner.
  a_strobe_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[3] |-> !m_axis_tlast_o)
    else $error("enable strobe left high on last port write");

  a_strobe_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tdata_o[3] |=>
      m_axis_tvalid_o && !m_axis_tdata_o[3] &&
      m_axis_tdata_o[7:4] == $past(m_axis_tdata_o[7:4]))
    else $error("strobe-high write not followed by matching strobe-low write");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output changed while stalled");

endmodule

bind char_lcd_nibble_interface lcdn_checker u_lcdn_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
